// ===== sv/rhsv_pkg.sv =====
package rhsv_pkg;

    localparam int FRACTION_BITS = 6;

    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 13;
    localparam int VAL_W = 13;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    // quotient bits produced by the long division, one per stage
    localparam int HUE_QBITS = HUE_W;
    localparam int SAT_QBITS = SAT_W;
    localparam int HUE_NUM_W = CH_W + HUE_QBITS;
    localparam int SAT_NUM_W = CH_W + SAT_QBITS;
    localparam int TOTAL_W   = 18;
    localparam int OFS_W     = 9;

    localparam int HUE_SLOPE = 60;
    localparam int HUE_OFS_R = 360;
    localparam int HUE_OFS_G = 120;
    localparam int HUE_OFS_B = 240;
    localparam int HUE_FULL  = 360 << FRACTION_BITS;
    localparam int PCT_SCALE = 100 << FRACTION_BITS;

    // value = max * PCT_SCALE / 255 by reciprocal multiply
    localparam int VAL_SHIFT = 29;
    localparam int VAL_PROD_W = 42;
    localparam longint unsigned VAL_RECIP = ((64'd1 << VAL_SHIFT) + 64'd254) / 64'd255;
    localparam logic [33:0] VAL_MULT = 34'(VAL_RECIP * PCT_SCALE);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [CH_W-1:0]      diff;
        logic [CH_W-1:0]      mx;
        logic                 grey;
        logic                 black;
    } rhsv_job_t;

endpackage

// ===== sv/rhsv_front.sv =====
module rhsv_front import rhsv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // red, green, blue
    output logic                 job_valid,
    output rhsv_job_t            job,
    input  logic                 push_ok
);

    logic            vld_reg;
    logic            vld_next;
    rhsv_job_t       job_reg;
    rhsv_job_t       job_next;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            red_max;
    logic            green_max;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] diff;
    logic [CH_W-1:0] op_a;
    logic [CH_W-1:0] op_b;
    logic [OFS_W-1:0] offset;
    logic [TOTAL_W-1:0] total;
    logic            accept;
    logic            push;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max) begin
            mx = red;
        end else if (green_max) begin
            mx = green;
        end else begin
            mx = blue;
        end
        mn = red;
        if (green < mn) begin
            mn = green;
        end
        if (blue < mn) begin
            mn = blue;
        end
        diff = mx - mn;
        if (red_max) begin
            op_a   = green;
            op_b   = blue;
            offset = OFS_W'(HUE_OFS_R);
        end else if (green_max) begin
            op_a   = blue;
            op_b   = red;
            offset = OFS_W'(HUE_OFS_G);
        end else begin
            op_a   = red;
            op_b   = green;
            offset = OFS_W'(HUE_OFS_B);
        end
        // 60*(a-b) + offset*diff, never negative
        total = TOTAL_W'(op_a) * TOTAL_W'(HUE_SLOPE)
              + TOTAL_W'(offset) * TOTAL_W'(diff)
              - TOTAL_W'(op_b) * TOTAL_W'(HUE_SLOPE);
        job_next.hue_num = HUE_NUM_W'(total) << FRACTION_BITS;
        job_next.sat_num = SAT_NUM_W'(diff) * SAT_NUM_W'(PCT_SCALE);
        job_next.diff    = diff;
        job_next.mx      = mx;
        job_next.grey    = (diff == '0);
        job_next.black   = (mx == '0);
    end

    assign s_tready = !vld_reg || push_ok;
    assign accept   = s_tvalid && s_tready;
    assign push     = vld_reg && push_ok;

    always_comb begin
        vld_next = vld_reg;
        if (accept) begin
            vld_next = 1'b1;
        end else if (push) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = vld_reg;
    assign job       = job_reg;

endmodule

// ===== sv/rhsv_fifo.sv =====
module rhsv_fifo import rhsv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  rhsv_job_t wr_data,
    output logic      push_ok,
    input  logic      pop,
    output rhsv_job_t rd_data,
    output logic      rd_valid
);

    rhsv_job_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ok  = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && push_ok;
    assign do_pop   = pop && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = FIFO_AW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = FIFO_AW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/rhsv_back.sv =====
module rhsv_back import rhsv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_valid,
    input  rhsv_job_t            job,
    output logic                 job_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // hue, saturation, brightness
);

    typedef struct packed {
        logic [CH_W-1:0]      hue_rem;
        logic [HUE_QBITS-1:0] hue_sh;
        logic [CH_W-1:0]      hue_div;
        logic [CH_W-1:0]      sat_rem;
        logic [SAT_QBITS-1:0] sat_sh;
        logic [CH_W-1:0]      sat_div;
        logic [VAL_W-1:0]     val;
        logic                 grey;
        logic                 black;
    } rhsv_stage_t;

    // one restoring step on the hue divider, and on the saturation divider when do_sat
    // is set; remaining dividend bits shift out of the top of *_sh as quotient bits shift in at the bottom
    function automatic rhsv_stage_t div_step(rhsv_stage_t s, logic do_sat);
        logic [CH_W:0] ht;
        logic [CH_W:0] st;
        rhsv_stage_t   r;
        r  = s;
        ht = {s.hue_rem, s.hue_sh[HUE_QBITS-1]};
        st = {s.sat_rem, s.sat_sh[SAT_QBITS-1]};
        if (ht >= {1'b0, s.hue_div}) begin
            r.hue_rem = CH_W'(ht - {1'b0, s.hue_div});
            r.hue_sh  = {s.hue_sh[HUE_QBITS-2:0], 1'b1};
        end else begin
            r.hue_rem = ht[CH_W-1:0];
            r.hue_sh  = {s.hue_sh[HUE_QBITS-2:0], 1'b0};
        end
        if (do_sat) begin
            if (st >= {1'b0, s.sat_div}) begin
                r.sat_rem = CH_W'(st - {1'b0, s.sat_div});
                r.sat_sh  = {s.sat_sh[SAT_QBITS-2:0], 1'b1};
            end else begin
                r.sat_rem = st[CH_W-1:0];
                r.sat_sh  = {s.sat_sh[SAT_QBITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    rhsv_stage_t            entry;
    logic [VAL_PROD_W-1:0]  val_prod;
    rhsv_stage_t            stage_reg  [HUE_QBITS];
    rhsv_stage_t            stage_next [HUE_QBITS];
    logic [HUE_QBITS-1:0]   vld_reg;
    logic [HUE_QBITS-1:0]   vld_next;
    logic                   out_vld_reg;
    logic [HUE_W-1:0]       out_hue_reg;
    logic [HUE_W-1:0]       out_hue_next;
    logic [SAT_W-1:0]       out_sat_reg;
    logic [SAT_W-1:0]       out_sat_next;
    logic [VAL_W-1:0]       out_val_reg;
    logic                   adv;
    rhsv_stage_t            last;

    assign adv     = !out_vld_reg || m_tready;
    assign job_pop = adv && job_valid;

    always_comb begin
        val_prod      = VAL_PROD_W'(job.mx) * VAL_PROD_W'(VAL_MULT);
        entry.hue_rem = job.hue_num[HUE_NUM_W-1:HUE_QBITS];
        entry.hue_sh  = job.hue_num[HUE_QBITS-1:0];
        entry.hue_div = job.diff;
        entry.sat_rem = job.sat_num[SAT_NUM_W-1:SAT_QBITS];
        entry.sat_sh  = job.sat_num[SAT_QBITS-1:0];
        entry.sat_div = job.mx;
        entry.val     = VAL_W'(val_prod >> VAL_SHIFT);
        entry.grey    = job.grey;
        entry.black   = job.black;
    end

    always_comb begin
        stage_next[0] = div_step(entry, 1'b1);
        vld_next[0]   = job_valid;
        for (int i = 1; i < HUE_QBITS; i++) begin
            stage_next[i] = div_step(stage_reg[i-1], i < SAT_QBITS);
            vld_next[i]   = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[HUE_QBITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < HUE_QBITS; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign last = stage_reg[HUE_QBITS-1];

    always_comb begin
        if (last.grey) begin
            out_hue_next = '0;
        end else if (last.hue_sh >= HUE_QBITS'(HUE_FULL)) begin
            out_hue_next = HUE_W'(last.hue_sh - HUE_QBITS'(HUE_FULL));
        end else begin
            out_hue_next = last.hue_sh;
        end
        out_sat_next = last.black ? '0 : last.sat_sh;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hue_reg <= out_hue_next;
            out_sat_reg <= out_sat_next;
            out_val_reg <= last.val;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(M_TDATA_W - HUE_W - SAT_W - VAL_W)'(0),
                       out_val_reg, out_sat_reg, out_hue_reg};

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_hue_reg < HUE_W'(HUE_FULL)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_sat_reg <= SAT_W'(PCT_SCALE)))
        else $error("saturation out of range");

    a_val_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> (out_val_reg <= VAL_W'(PCT_SCALE)))
        else $error("brightness out of range");

    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_tready) |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while output stalled");

endmodule

// ===== sv/rgb_to_hsv_pixel_core.sv =====
// RGB to HSV converter: one 8-bit red/green/blue pixel per word in, one word
// of hue (degrees), saturation and brightness (percent) out, all with six
// fraction bits and rounded down. A word is accepted every clock while the
// output is taken. A word passes one classify stage, the two-word queue,
// fifteen restoring-division stages (one hue quotient bit each, with the
// saturation divider side by side) and the output register.
module rgb_to_hsv_pixel_core import rhsv_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // hue[14:0], saturation[27:15], brightness[40:28]
);

    rhsv_job_t front_job;
    logic      front_valid;
    logic      push_ok;
    rhsv_job_t back_job;
    logic      back_valid;
    logic      back_pop;

    rhsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (front_valid),
        .job       (front_job),
        .push_ok   (push_ok)
    );

    rhsv_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_valid),
        .wr_data  (front_job),
        .push_ok  (push_ok),
        .pop      (back_pop),
        .rd_data  (back_job),
        .rd_valid (back_valid)
    );

    rhsv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (back_valid),
        .job       (back_job),
        .job_pop   (back_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
